/* hw/rtl/kmst_pkg.sv */
package kmst_pkg;

  // graph sizes
  localparam int VERTS       = 16;
  localparam int VB          = $clog2(VERTS);
  localparam int NB          = VB + 1;
  localparam int WB          = 16;
  localparam int CB          = 20;
  localparam int CFG_BITS    = 5;
  localparam int MAT_AW      = 2 * VB;
  localparam int MAT_DEPTH   = VERTS * VERTS;
  localparam int VC_RESET    = 5;
  localparam int VC_MIN      = 2;

  // item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_RUN   = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_FLUSH,
    ST_DECIDE,
    ST_RELABEL,
    ST_RFLUSH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic write;
    logic start;
    logic init_step;
    logic scan_start;
    logic scan_step;
    logic emit;
    logic relabel_start;
    logic relabel_step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic sweep_done;
    logic scan_last;
    logic out_free;
    logic found;
    logic final_edge;
  } sts_t;

endpackage

/* hw/rtl/kmst_ifs.sv */
interface kmst_item_if;
  import kmst_pkg::*;
  logic          valid;
  logic          ready;
  logic          func;
  logic [VB-1:0] row;
  logic [VB-1:0] col;
  logic [WB-1:0] weight;

  modport source (output valid, func, row, col, weight, input ready);
  modport sink (input valid, func, row, col, weight, output ready);
endinterface

interface kmst_result_if;
  import kmst_pkg::*;
  logic          valid;
  logic          ready;
  logic [VB-1:0] edge_number;
  logic [VB-1:0] from_vertex;
  logic [VB-1:0] to_vertex;
  logic [WB-1:0] edge_cost;
  logic [CB-1:0] total_cost;
  logic          status;
  logic          last;

  modport source (output valid, edge_number, from_vertex, to_vertex, edge_cost,
                  total_cost, status, last, input ready);
  modport sink (input valid, edge_number, from_vertex, to_vertex, edge_cost,
                total_cost, status, last, output ready);
endinterface

/* hw/rtl/kruskal_mst_matrix_top.sv */
// channel  | role  | word fields
// ---------+-------+---------------------------------------------------------------
// item     | sink  | func, row, col, weight
// result   | source| edge_number, from_vertex, to_vertex, edge_cost, total_cost,
//          |       | status, last
// cfg      | write | cfg_we, cfg_data (vertex_count)
//
// after reset a clearing pass zeroes the weight matrix; no item is taken
// a run, from its start word to its last result word for n vertices, performs a label init
// of all 16 labels, then per round an n*n scan of the single read port of the weight matrix
// followed, unless the run ends in that round, by a relabel sweep
// a run emits up to n-1 words; each round waits while the previous word is not taken
// items are accepted only when no run is in progress; a held result does not block them
module kruskal_mst_matrix_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [kmst_pkg::CFG_BITS-1:0] cfg_data,
  kmst_item_if.sink                     item,
  kmst_result_if.source                 result
);
  import kmst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing
  kmst_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_func  (item.func),
    .item_ready (item.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // storage and arithmetic
  kmst_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .item_row        (item.row),
    .item_col        (item.col),
    .item_weight     (item.weight),
    .res_ready       (result.ready),
    .res_valid       (result.valid),
    .res_edge_number (result.edge_number),
    .res_from_vertex (result.from_vertex),
    .res_to_vertex   (result.to_vertex),
    .res_edge_cost   (result.edge_cost),
    .res_total_cost  (result.total_cost),
    .res_status      (result.status),
    .res_last        (result.last)
  );

endmodule

/* hw/rtl/kmst_ctrl.sv */
module kmst_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  logic           item_func,
  output logic           item_ready,
  input  kmst_pkg::sts_t sts,
  output kmst_pkg::cmd_t cmd
);
  import kmst_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:   if (sts.clear_done) state_next = ST_IDLE;
      ST_IDLE:    if (item_valid && item_func == FUNC_RUN) state_next = ST_INIT;
      ST_INIT:    if (sts.sweep_done) state_next = ST_SCAN;
      ST_SCAN:    if (sts.scan_last) state_next = ST_FLUSH;
      ST_FLUSH:   state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (sts.out_free) begin
          state_next = (!sts.found || sts.final_edge) ? ST_IDLE : ST_RELABEL;
        end
      end
      ST_RELABEL: if (sts.sweep_done) state_next = ST_RFLUSH;
      ST_RFLUSH:  state_next = ST_SCAN;
      default:    state_next = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        item_ready = 1'b1;
        cmd.write  = item_valid && item_func == FUNC_WRITE;
        cmd.start  = item_valid && item_func == FUNC_RUN;
      end
      ST_INIT: begin
        cmd.init_step  = 1'b1;
        cmd.scan_start = sts.sweep_done;
      end
      ST_SCAN:  cmd.scan_step = 1'b1;
      ST_FLUSH: cmd = '0;
      ST_DECIDE: begin
        cmd.emit          = sts.out_free;
        cmd.relabel_start = sts.out_free;
      end
      ST_RELABEL: cmd.relabel_step = 1'b1;
      ST_RFLUSH:  cmd.scan_start = 1'b1;
      default:    cmd = '0;
    endcase
  end

endmodule

/* hw/rtl/kmst_dp.sv */
module kmst_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  kmst_pkg::cmd_t                cmd,
  output kmst_pkg::sts_t                sts,
  input  logic                          cfg_we,
  input  logic [kmst_pkg::CFG_BITS-1:0] cfg_data,
  input  logic [kmst_pkg::VB-1:0]       item_row,
  input  logic [kmst_pkg::VB-1:0]       item_col,
  input  logic [kmst_pkg::WB-1:0]       item_weight,
  input  logic                          res_ready,
  output logic                          res_valid,
  output logic [kmst_pkg::VB-1:0]       res_edge_number,
  output logic [kmst_pkg::VB-1:0]       res_from_vertex,
  output logic [kmst_pkg::VB-1:0]       res_to_vertex,
  output logic [kmst_pkg::WB-1:0]       res_edge_cost,
  output logic [kmst_pkg::CB-1:0]       res_total_cost,
  output logic                          res_status,
  output logic                          res_last
);
  import kmst_pkg::*;

  logic [CFG_BITS-1:0] vertex_count;
  logic [NB-1:0]       nv;
  logic [NB-1:0]       nv_clamp;
  logic [VB-1:0]       nv_m1;

  logic [MAT_AW-1:0]   clr_addr;
  logic [WB-1:0]       mat [MAT_DEPTH];
  logic [WB-1:0]       c_rd;

  logic [VB-1:0]       lab [VERTS];
  logic [VB-1:0]       la_rd, lb_rd;
  logic [VB-1:0]       la_addr;

  logic [VB-1:0]       vcnt;
  logic [VB-1:0]       scan_i, scan_j;
  logic                pv;
  logic [VB-1:0]       pi, pj;

  logic                rl_valid;
  logic [VB-1:0]       rl_addr;

  logic                found;
  logic [WB-1:0]       best_w;
  logic [VB-1:0]       ba, bb, bla, blb;

  logic [VB-1:0]       edges;
  logic [CB-1:0]       total;
  logic [CB-1:0]       total_next;

  // vertex count register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CFG_BITS'(VC_RESET);
    end else if (cfg_we) begin
      vertex_count <= cfg_data;
    end
  end

  // clamp vertex count into the supported range
  always_comb begin
    if (NB'(vertex_count) < NB'(VC_MIN)) begin
      nv_clamp = NB'(VC_MIN);
    end else if (NB'(vertex_count) > NB'(VERTS)) begin
      nv_clamp = NB'(VERTS);
    end else begin
      nv_clamp = NB'(vertex_count);
    end
  end

  assign nv_m1 = VB'(nv - NB'(1));

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + MAT_AW'(1);
    end
  end

  // weight matrix, one write and one read port
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mat[clr_addr] <= '0;
    end else if (cmd.write) begin
      mat[{item_row, item_col}] <= item_weight;
    end
    c_rd <= mat[{scan_i, scan_j}];
  end

  // label store, one write and two read ports
  assign la_addr = cmd.relabel_step ? vcnt : scan_i;

  always_ff @(posedge clk) begin
    if (cmd.init_step) begin
      lab[vcnt] <= vcnt;
    end else if (rl_valid && la_rd == bla) begin
      lab[rl_addr] <= blb;
    end
    la_rd <= lab[la_addr];
    lb_rd <= lab[scan_j];
  end

  // sweep counter for label init and relabel
  always_ff @(posedge clk) begin
    if (rst) begin
      vcnt     <= '0;
      rl_valid <= 1'b0;
    end else begin
      rl_valid <= cmd.relabel_step;
      if (cmd.start || cmd.relabel_start) begin
        vcnt <= '0;
      end else if (cmd.init_step || cmd.relabel_step) begin
        vcnt <= vcnt + VB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rl_addr <= vcnt;
  end

  // row-major scan counters
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_i <= '0;
      scan_j <= '0;
      pv     <= 1'b0;
    end else begin
      pv <= cmd.scan_step;
      if (cmd.scan_start) begin
        scan_i <= '0;
        scan_j <= '0;
      end else if (cmd.scan_step) begin
        if (scan_j == nv_m1) begin
          scan_j <= '0;
          scan_i <= scan_i + VB'(1);
        end else begin
          scan_j <= scan_j + VB'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pi <= scan_i;
    pj <= scan_j;
  end

  // keep the strictly smallest usable edge
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.scan_start) begin
      found <= 1'b0;
    end else if (pv && c_rd != '0 && (!found || c_rd < best_w) && la_rd != lb_rd) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pv && c_rd != '0 && (!found || c_rd < best_w) && la_rd != lb_rd) begin
      best_w <= c_rd;
      ba     <= pi;
      bb     <= pj;
      bla    <= la_rd;
      blb    <= lb_rd;
    end
  end

  // run totals
  assign total_next = total + CB'(best_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      edges <= '0;
      total <= '0;
      nv    <= NB'(VC_RESET);
    end else if (cmd.start) begin
      edges <= '0;
      total <= '0;
      nv    <= nv_clamp;
    end else if (cmd.emit && found) begin
      edges <= edges + VB'(1);
      total <= total_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_edge_number <= edges;
      res_from_vertex <= found ? ba : '0;
      res_to_vertex   <= found ? bb : '0;
      res_edge_cost   <= found ? best_w : '0;
      res_total_cost  <= found ? total_next : total;
      res_status      <= !found;
      res_last        <= !found || sts.final_edge;
    end
  end

  // status back to the controller
  always_comb begin
    sts.clear_done = clr_addr == MAT_AW'(MAT_DEPTH - 1);
    sts.sweep_done = vcnt == VB'(VERTS - 1);
    sts.scan_last  = scan_i == nv_m1 && scan_j == nv_m1;
    sts.out_free   = !res_valid || res_ready;
    sts.found      = found;
    sts.final_edge = (NB'(edges) + NB'(1)) == (nv - NB'(1));
  end

endmodule

/* hw/rtl/kmst_checker.sv */
module kmst_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    item_valid,
  input logic                    item_ready,
  input logic                    item_func,
  input logic                    res_valid,
  input logic                    res_ready,
  input logic [kmst_pkg::VB-1:0] res_from_vertex,
  input logic [kmst_pkg::VB-1:0] res_to_vertex,
  input logic [kmst_pkg::WB-1:0] res_edge_cost,
  input logic [kmst_pkg::CB-1:0] res_total_cost,
  input logic                    res_status,
  input logic                    res_last
);
  import kmst_pkg::*;

  // a stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_total_cost)
      && $stable(res_edge_cost) && $stable(res_from_vertex) && $stable(res_to_vertex))
    else $error("result word changed while stalled");

  // a disconnected status ends the run with empty edge fields
  a_disc_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status |-> res_last && res_edge_cost == '0
      && res_from_vertex == '0 && res_to_vertex == '0)
    else $error("disconnected word malformed");

  // a chosen edge always has a positive weight
  a_edge_pos: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_status |-> res_edge_cost != '0)
    else $error("chosen edge with zero weight");

  // a run start makes the block busy
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item_func == FUNC_RUN |=> !item_ready)
    else $error("item taken during a run");

  // the clearing pass follows reset
  a_clear_busy: assert property (@(posedge clk)
    rst |=> !item_ready)
    else $error("item ready during clearing pass");

endmodule

bind kruskal_mst_matrix_top kmst_checker u_kmst_checker (
  .clk             (clk),
  .rst             (rst),
  .item_valid      (item.valid),
  .item_ready      (item.ready),
  .item_func       (item.func),
  .res_valid       (result.valid),
  .res_ready       (result.ready),
  .res_from_vertex (result.from_vertex),
  .res_to_vertex   (result.to_vertex),
  .res_edge_cost   (result.edge_cost),
  .res_total_cost  (result.total_cost),
  .res_status      (result.status),
  .res_last        (result.last)
);

/* bench/testbench.sv */
module testbench;
  import kmst_pkg::*;

  localparam int RANDOM_ITEMS  = 115;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_CYCLES  = 100;

  // one result word as seen on the result channel
  typedef struct packed {
    logic [VB-1:0] num;
    logic [VB-1:0] src;
    logic [VB-1:0] dst;
    logic [WB-1:0] cost;
    logic [CB-1:0] total;
    logic          disc;
    logic          last;
  } tree_word_t;

  // shadow of the weight matrix and expected tree words
  class mst_checker;
    logic [WB-1:0]       weights [VERTS][VERTS];
    logic [CFG_BITS-1:0] vcount;
    int                  parent_of [VERTS];
    tree_word_t          tree_words [$];
    int                  errors;

    function new();
      int i, j;
      for (i = 0; i < VERTS; i++)
        for (j = 0; j < VERTS; j++)
          weights[i][j] = '0;
      vcount = CFG_BITS'(VC_RESET);
      errors = 0;
    endfunction

    function void set_vertex_count(logic [CFG_BITS-1:0] v);
      vcount = v;
    endfunction

    // register value clamped to the usable vertex range
    function int active_count();
      if (vcount < VC_MIN) return VC_MIN;
      if (vcount > VERTS) return VERTS;
      return int'(vcount);
    endfunction

    function int root_of(int v);
      while (parent_of[v] != v) v = parent_of[v];
      return v;
    endfunction

    function string show(tree_word_t w);
      return $sformatf("num=%0d from=%0d to=%0d cost=%0d total=%0d status=%0d last=%0d",
                       w.num, w.src, w.dst, w.cost, w.total, w.disc, w.last);
    endfunction

    // accepted item: store a weight, or work out the whole spanning tree run
    function void note_item(logic f, logic [VB-1:0] r, logic [VB-1:0] c, logic [WB-1:0] w);
      int nv, chosen, best, ba, bb, i, j, ra, rb;
      bit found;
      logic [CB-1:0] sum;
      tree_word_t wd;
      if (f == FUNC_WRITE) begin
        weights[r][c] = w;
        return;
      end
      nv = active_count();
      for (i = 0; i < VERTS; i++) parent_of[i] = i;
      chosen = 0;
      sum = '0;
      while (chosen < nv - 1) begin
        found = 0;
        best = 0;
        ba = 0;
        bb = 0;
        // row-major scan, strict compare keeps the first of equal weights
        for (i = 0; i < nv; i++)
          for (j = 0; j < nv; j++)
            if (weights[i][j] != 0 && (!found || int'(weights[i][j]) < best) &&
                root_of(i) != root_of(j)) begin
              found = 1;
              best = int'(weights[i][j]);
              ba = i;
              bb = j;
            end
        wd.num = chosen[VB-1:0];
        if (!found) begin
          // no usable edge left: one disconnected word ends the run
          wd.src = '0;
          wd.dst = '0;
          wd.cost = '0;
          wd.total = sum;
          wd.disc = 1'b1;
          wd.last = 1'b1;
          tree_words.push_back(wd);
          return;
        end
        ra = root_of(ba);
        rb = root_of(bb);
        parent_of[ra] = rb;
        sum = sum + CB'(best);
        wd.src = ba[VB-1:0];
        wd.dst = bb[VB-1:0];
        wd.cost = best[WB-1:0];
        wd.total = sum;
        wd.disc = 1'b0;
        wd.last = (chosen + 1 == nv - 1);
        tree_words.push_back(wd);
        chosen++;
      end
    endfunction

    function void check_word(tree_word_t got);
      tree_word_t want;
      if (tree_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: %s", show(got));
        return;
      end
      want = tree_words.pop_front();
      if (got.num !== want.num || got.src !== want.src || got.dst !== want.dst ||
          got.cost !== want.cost || got.total !== want.total ||
          got.disc !== want.disc || got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected %s", show(want));
          $display("          actual   %s", show(got));
        end
      end
    endfunction

    function int pending();
      return tree_words.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [CFG_BITS-1:0] cfg_data;
  bit                  calm_in;
  bit                  calm_out;

  kmst_item_if   item_bus ();
  kmst_result_if result_bus ();

  mst_checker sb = new();

  kruskal_mst_matrix_top DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .item     (item_bus),
    .result   (result_bus)
  );

  always #5 clk = ~clk;

  // mostly short gaps, a few long ones
  function int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function logic [WB-1:0] pick_weight(bit tie);
    if (tie) return WB'($urandom_range(1, 4));
    if ($urandom_range(0, 7) == 0) return '1;
    return WB'($urandom_range(1, 65535));
  endfunction

  function logic [CFG_BITS-1:0] pick_vertex_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return CFG_BITS'($urandom_range(2, 6));
    if (r < 85) return CFG_BITS'($urandom_range(7, 16));
    if (r < 90) return CFG_BITS'(VERTS);
    if (r < 95) return CFG_BITS'($urandom_range(0, 1));
    return CFG_BITS'($urandom_range(17, 31));
  endfunction

  // present one word on the item channel and hold it until taken
  task automatic send_item(logic f, logic [VB-1:0] r, logic [VB-1:0] c, logic [WB-1:0] w);
    int gap;
    gap = pick_gap(calm_in);
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid  <= 1'b1;
    item_bus.func   <= f;
    item_bus.row    <= r;
    item_bus.col    <= c;
    item_bus.weight <= w;
    do @(posedge clk); while (item_bus.ready !== 1'b1);
    sb.note_item(f, r, c, w);
  endtask

  // wait for every word of the last run, let the block settle
  task automatic wait_idle();
    item_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertices(logic [CFG_BITS-1:0] v);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.set_vertex_count(v);
  endtask

  // result channel: random back-pressure and checking
  initial begin : result_sink
    int hold;
    tree_word_t got;
    hold = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
        got.num   = result_bus.edge_number;
        got.src   = result_bus.from_vertex;
        got.dst   = result_bus.to_vertex;
        got.cost  = result_bus.edge_cost;
        got.total = result_bus.total_cost;
        got.disc  = result_bus.status;
        got.last  = result_bus.last;
        sb.check_word(got);
      end
      if (hold > 0) begin
        hold--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
        if (!calm_out && $urandom_range(0, 2) == 0) hold = pick_gap(1'b0);
      end
    end
  end

  initial begin : stimulus
    int n_rand, nv, k, mode;
    bit tie;
    logic [VB-1:0] a, b;
    calm_in  = 1'b0;
    calm_out = 1'b0;
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_data        <= '0;
    item_bus.valid  <= 1'b0;
    item_bus.func   <= FUNC_WRITE;
    item_bus.row    <= '0;
    item_bus.col    <= '0;
    item_bus.weight <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty matrix at the reset vertex count: disconnected at once
    send_item(FUNC_RUN, '0, '0, '0);
    // max weight, tied weights, self loop, mirrored tie, entries past the used vertices
    send_item(FUNC_WRITE, 4'd0, 4'd1, 16'hFFFF);
    send_item(FUNC_WRITE, 4'd1, 4'd2, 16'd5);
    send_item(FUNC_WRITE, 4'd2, 4'd3, 16'd5);
    send_item(FUNC_WRITE, 4'd0, 4'd0, 16'd1);
    send_item(FUNC_WRITE, 4'd3, 4'd4, 16'd9);
    send_item(FUNC_WRITE, 4'd4, 4'd3, 16'd9);
    send_item(FUNC_WRITE, 4'd15, 4'd15, 16'hFFFF);
    send_item(FUNC_WRITE, 4'd15, 4'd0, 16'd1);
    send_item(FUNC_RUN, 4'd15, 4'd15, 16'hFFFF);
    // erase an edge: vertex 0 keeps only its self loop
    send_item(FUNC_WRITE, 4'd0, 4'd1, 16'd0);
    send_item(FUNC_RUN, '0, '0, '0);
    // smallest graph, then counts below and above the range
    set_vertices(5'd2);
    send_item(FUNC_RUN, '0, '0, '0);
    send_item(FUNC_WRITE, 4'd1, 4'd0, 16'd3);
    send_item(FUNC_RUN, '0, '0, '0);
    set_vertices(5'd0);
    send_item(FUNC_RUN, '0, '0, '0);
    set_vertices(5'd1);
    send_item(FUNC_RUN, '0, '0, '0);
    set_vertices(5'd31);
    send_item(FUNC_RUN, '0, '0, '0);
    set_vertices(5'd17);
    send_item(FUNC_RUN, '0, '0, '0);
    set_vertices(5'd16);
    send_item(FUNC_RUN, '0, '0, '0);

    // random phases: set a count, build a graph, start a run
    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      set_vertices(pick_vertex_count());
      calm_in  = ($urandom_range(0, 4) == 0);
      calm_out = ($urandom_range(0, 4) == 0);
      nv = sb.active_count();
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
        // spanning set of edges over the used vertices, plus a few extras
        tie = ($urandom_range(0, 2) == 0);
        for (k = 1; k < nv; k++) begin
          a = k[VB-1:0];
          b = VB'($urandom_range(0, k - 1));
          if ($urandom_range(0, 1) == 1)
            send_item(FUNC_WRITE, a, b, pick_weight(tie));
          else
            send_item(FUNC_WRITE, b, a, pick_weight(tie));
          n_rand++;
        end
        repeat ($urandom_range(0, 3)) begin
          send_item(FUNC_WRITE, VB'($urandom_range(0, nv - 1)),
                    VB'($urandom_range(0, nv - 1)), pick_weight(tie));
          n_rand++;
        end
      end else if (mode < 9) begin
        // scattered writes anywhere in the matrix, zeros included
        repeat ($urandom_range(1, 4)) begin
          send_item(FUNC_WRITE, VB'($urandom_range(0, VERTS - 1)),
                    VB'($urandom_range(0, VERTS - 1)),
                    ($urandom_range(0, 3) == 0) ? '0 : WB'($urandom_range(0, 65535)));
          n_rand++;
        end
      end else begin
        // remove edges among the used vertices
        repeat ($urandom_range(1, nv)) begin
          send_item(FUNC_WRITE, VB'($urandom_range(0, nv - 1)),
                    VB'($urandom_range(0, nv - 1)), '0);
          n_rand++;
        end
      end
      send_item(FUNC_RUN, VB'($urandom_range(0, VERTS - 1)), VB'($urandom_range(0, VERTS - 1)),
                WB'($urandom_range(0, 65535)));
      n_rand++;
    end

    item_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin : watchdog
    #40_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
